@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ hdl/apf_pkg.sv @@
// ----------------------------------------------------------------------------
// apf_pkg
// Formats, coefficient tables, codes and types of the all-pole filter.
// ----------------------------------------------------------------------------
package apf_pkg;

  localparam int FILTER_ORDER = 10;
  localparam int NCOEF        = FILTER_ORDER + 1;
  localparam int TAP_W        = $clog2(NCOEF);

  localparam int SAMPLE_W = 24;
  localparam int HIST_W   = 48;
  localparam int COEF_W   = 64;
  localparam int IDX_W    = 4;
  localparam int TRIM_W   = 16;
  localparam int XSH      = 16;

  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 25;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 116;
  localparam int RND_POS  = 55;
  localparam int FOLD_W   = 16;
  localparam int QUO_W    = 40;
  localparam int FQ_W     = 39;
  localparam int FQ_LO_W  = 24;

  localparam logic [63:0] DEC_SCALE = 64'd1000000000000;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TRIM   = 1'b1;

  localparam logic [1:0] PART_LAST  = 2'd3;
  localparam logic [1:0] TPART_LAST = 2'd1;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd1 << (RND_POS - 1));
  localparam logic signed [ACC_W-1:0] DIV_BIAS   = ACC_W'(32767);
  localparam logic [FOLD_W-1:0]       FOLD_MAX   = '1;

  // base coefficients in units of 1e-12
  localparam longint BASE_DEC [17] = '{
    64'sd811044, 64'sd8943665402000, -64'sd36838895290000, 64'sd92016978870000,
    -64'sd154337906000000, 64'sd181623328900000, -64'sd151865123500000,
    64'sd89096141140000, -64'sd35102985110000, 64'sd8388101016000,
    -64'sd923313471000, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0
  };

  function automatic logic [COEF_W-1:0] dec_to_q55(input longint m);
    logic              neg;
    logic [63:0]       a;
    logic [63:0]       q;
    logic [63:0]       r;
    logic [63:0]       frac;
    logic [63:0]       res;
    int                i;
    neg  = (m < 0);
    a    = neg ? (64'd0 - 64'(m)) : 64'(m);
    q    = a / DEC_SCALE;
    r    = a % DEC_SCALE;
    frac = '0;
    for (i = 0; i < RND_POS; i++) begin
      r    = r << 1;
      frac = frac << 1;
      if (r >= DEC_SCALE) begin
        r    = r - DEC_SCALE;
        frac = frac | 64'd1;
      end
    end
    if ((r << 1) >= DEC_SCALE) begin
      frac = frac + 64'd1;
    end
    res = (q << RND_POS) + frac;
    return neg ? (64'd0 - res) : res;
  endfunction

  function automatic logic [NCOEF-1:0][COEF_W-1:0] base_table();
    logic [NCOEF-1:0][COEF_W-1:0] t;
    int                           k;
    for (k = 0; k < NCOEF; k++) begin
      t[k] = dec_to_q55(BASE_DEC[k]);
    end
    return t;
  endfunction

  localparam logic [NCOEF-1:0][COEF_W-1:0] BASE_Q55 = base_table();
  localparam logic [FQ_W-1:0] FACT0_Q55 = FQ_W'(dec_to_q55(64'sd10000000));
  localparam logic [FQ_W-1:0] FACT_Q55  = FQ_W'(dec_to_q55(64'sd1000000));

  typedef enum logic [1:0] {SH_0, SH_24, SH_32, SH_56} mac_shift_t;

  typedef enum logic {BIAS_ROUND, BIAS_DIV} mac_bias_t;

  typedef struct packed {
    logic       clear;
    mac_bias_t  bias;
    logic       issue;
    mac_shift_t shift;
    logic       fold;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_DRAIN, ST_FIN, ST_TMUL, ST_TDRAIN, ST_TDIV
  } apf_state_t;

endpackage

@@ hdl/apf_in_if.sv @@
// ----------------------------------------------------------------------------
// apf_in_if
// Request channel: sample to filter or coefficient trim.
// ----------------------------------------------------------------------------
interface apf_in_if import apf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [IDX_W-1:0]           coef_index;
  logic [TRIM_W-1:0]          trim_value;

  modport source (output valid, req_type, sample_in, coef_index, trim_value, input ready);
  modport sink   (input valid, req_type, sample_in, coef_index, trim_value, output ready);
endinterface

@@ hdl/apf_out_if.sv @@
// ----------------------------------------------------------------------------
// apf_out_if
// Result channel: filtered sample and saturation flag.
// ----------------------------------------------------------------------------
interface apf_out_if import apf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       clipped;

  modport source (output valid, sample_out, clipped, input ready);
  modport sink   (input valid, sample_out, clipped, output ready);
endinterface

@@ hdl/apf_mac.sv @@
// ----------------------------------------------------------------------------
// apf_mac
// Shared 33x25 signed multiplier with a shifted 116-bit accumulator and a
// fold step for division by 65535.
// ----------------------------------------------------------------------------
module apf_mac import apf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mac_ctl_t                  ctl,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic signed [MUL_B_W-1:0] op_b,
  output logic signed [ACC_W-1:0]   acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  mac_shift_t               prod_sh_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  pext;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  low_part;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.issue;
    end
    prod_r    <= op_a * op_b;
    prod_sh_r <= ctl.shift;
  end

  always_comb begin
    pext = ACC_W'(prod_r);
    case (prod_sh_r)
      SH_0:    addend = pext;
      SH_24:   addend = pext <<< 24;
      SH_32:   addend = pext <<< 32;
      SH_56:   addend = pext <<< 56;
      default: addend = pext;
    endcase
  end

  always_comb begin
    low_part = {{(ACC_W-FOLD_W){1'b0}}, acc_r[FOLD_W-1:0]};
    acc_nxt  = acc_r;
    if (ctl.clear) begin
      acc_nxt = (ctl.bias == BIAS_DIV) ? DIV_BIAS : ROUND_BIAS;
    end else if (ctl.fold) begin
      acc_nxt = (acc_r >>> FOLD_W) + low_part;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + addend;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

@@ hdl/all_pole_iir_filter_trimmable_top.sv @@
// ----------------------------------------------------------------------------
// all_pole_iir_filter_trimmable_top
// Tenth-order all-pole recursive filter with trimmable coefficients.
//
// in_ch carries requests: req_type 0 filters sample_in (Q1.23), req_type 1
// trims coefficient coef_index to base + (2t-1)*factor. A trim of zero on
// index 0 first restores all coefficients and clears the history. A trim
// with an index above the filter order is dropped.
// out_ch carries one result per sample: sample_out (Q1.23, saturated) and
// clipped. Trims give no result.
// A sample walks four partial products per tap through the single shared
// multiplier for all 11 taps, then a drain step and a finish step; the
// finish step waits while the result register is full and not read. A new
// sample is taken only after that. A trim takes two multiplies, then fold
// steps of the division by 65535. in_ch.ready is high only while idle.
// The result register decouples the sides: a stalled receiver blocks the
// block only when the next result is ready and the register is still full.
// Synchronous reset clears the history, loads the base coefficients and
// empties the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module all_pole_iir_filter_trimmable_top import apf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  apf_in_if.sink    in_ch,
  apf_out_if.source out_ch
);

  apf_state_t                 state_r;
  apf_state_t                 state_nxt;
  logic [TAP_W-1:0]           tap_r;
  logic [TAP_W-1:0]           tap_nxt;
  logic [1:0]                 part_r;
  logic [1:0]                 part_nxt;
  logic [QUO_W-1:0]           q_r;
  logic [QUO_W-1:0]           q_nxt;

  logic signed [SAMPLE_W-1:0] x_r;
  logic [TAP_W-1:0]           idx_r;
  logic [TRIM_W-1:0]          mag_r;
  logic                       neg_r;
  logic [COEF_W-1:0]          coef_r [NCOEF];
  logic [HIST_W-1:0]          hist_r [FILTER_ORDER];
  logic [HIST_W-1:0]          hin [NCOEF];

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_clip_r;

  mac_ctl_t                   mac_ctl;
  logic signed [MUL_A_W-1:0]  op_a;
  logic signed [MUL_B_W-1:0]  op_b;
  logic signed [ACC_W-1:0]    acc;

  logic                       in_rdy;
  logic                       take_smp;
  logic                       take_trim;
  logic                       restore;
  logic                       fin_go;
  logic                       coef_wr;

  logic [COEF_W-1:0]          c_sel;
  logic [HIST_W-1:0]          h_sel;
  logic [FQ_W-1:0]            fq;
  logic [TRIM_W:0]            t2;
  logic [TRIM_W-1:0]          mag_in;

  logic                       h_ok;
  logic [HIST_W-1:0]          hval;
  logic signed [HIST_W:0]     ysum;
  logic signed [32:0]         ys_full;
  logic                       y_ok;
  logic signed [SAMPLE_W-1:0] ysat;
  logic [QUO_W-1:0]           qf;
  logic [COEF_W-1:0]          dlt;

  apf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  always_comb begin
    hin[0] = {{(HIST_W-SAMPLE_W-XSH){x_r[SAMPLE_W-1]}}, x_r, {XSH{1'b0}}};
    for (int k = 0; k < FILTER_ORDER; k++) begin
      hin[k+1] = hist_r[k];
    end
  end

  assign c_sel  = coef_r[tap_r];
  assign h_sel  = hin[tap_r];
  assign fq     = (idx_r == '0) ? FACT0_Q55 : FACT_Q55;
  assign t2     = {in_ch.trim_value, 1'b0};
  assign mag_in = in_ch.trim_value[TRIM_W-1] ? TRIM_W'(t2 - 17'd65535)
                                             : TRIM_W'(17'd65535 - t2);

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    part_nxt  = part_r;
    q_nxt     = q_r;
    mac_ctl   = '0;
    op_a      = '0;
    op_b      = '0;
    in_rdy    = 1'b0;
    take_smp  = 1'b0;
    take_trim = 1'b0;
    restore   = 1'b0;
    fin_go    = 1'b0;
    coef_wr   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.req_type == REQ_SAMPLE) begin
            take_smp      = 1'b1;
            mac_ctl.clear = 1'b1;
            mac_ctl.bias  = BIAS_ROUND;
            tap_nxt       = '0;
            part_nxt      = '0;
            state_nxt     = ST_MAC;
          end else if (in_ch.coef_index <= IDX_W'(FILTER_ORDER)) begin
            take_trim     = 1'b1;
            restore       = (in_ch.coef_index == '0) && (in_ch.trim_value == '0);
            mac_ctl.clear = 1'b1;
            mac_ctl.bias  = BIAS_DIV;
            part_nxt      = '0;
            q_nxt         = '0;
            state_nxt     = ST_TMUL;
          end
        end
      end
      ST_MAC: begin
        mac_ctl.issue = 1'b1;
        op_a = part_r[1] ? {c_sel[COEF_W-1], c_sel[COEF_W-1:32]} : {1'b0, c_sel[31:0]};
        op_b = part_r[0] ? {h_sel[HIST_W-1], h_sel[HIST_W-1:24]} : {1'b0, h_sel[23:0]};
        case (part_r)
          2'd0:    mac_ctl.shift = SH_0;
          2'd1:    mac_ctl.shift = SH_24;
          2'd2:    mac_ctl.shift = SH_32;
          default: mac_ctl.shift = SH_56;
        endcase
        part_nxt = part_r + 2'd1;
        if (part_r == PART_LAST) begin
          tap_nxt = tap_r + TAP_W'(1);
          if (tap_r == TAP_W'(FILTER_ORDER)) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          fin_go    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_TMUL: begin
        mac_ctl.issue = 1'b1;
        op_a = {{(MUL_A_W-TRIM_W){1'b0}}, mag_r};
        op_b = part_r[0] ? {{(MUL_B_W-FQ_W+FQ_LO_W){1'b0}}, fq[FQ_W-1:FQ_LO_W]}
                         : {1'b0, fq[FQ_LO_W-1:0]};
        mac_ctl.shift = part_r[0] ? SH_24 : SH_0;
        part_nxt = part_r + 2'd1;
        if (part_r == TPART_LAST) begin
          state_nxt = ST_TDRAIN;
        end
      end
      ST_TDRAIN: begin
        state_nxt = ST_TDIV;
      end
      ST_TDIV: begin
        if (|acc[ACC_W-1:FOLD_W]) begin
          mac_ctl.fold = 1'b1;
          q_nxt        = q_r + acc[FOLD_W+QUO_W-1:FOLD_W];
        end else begin
          coef_wr   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= '0;
      part_r  <= '0;
      q_r     <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      part_r  <= part_nxt;
      q_r     <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_smp) begin
      x_r <= in_ch.sample_in;
    end
    if (take_trim) begin
      idx_r <= TAP_W'(in_ch.coef_index);
      mag_r <= mag_in;
      neg_r <= ~in_ch.trim_value[TRIM_W-1];
    end
  end

  // round and saturate to history, then to the output format
  always_comb begin
    h_ok    = (&acc[ACC_W-1:HIST_W+RND_POS-1]) || !(|acc[ACC_W-1:HIST_W+RND_POS-1]);
    hval    = h_ok ? acc[HIST_W+RND_POS-1:RND_POS]
                   : (acc[ACC_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}});
    ysum    = $signed({hval[HIST_W-1], hval}) + (HIST_W+1)'(32768);
    ys_full = ysum[HIST_W:XSH];
    y_ok    = (&ys_full[32:SAMPLE_W-1]) || !(|ys_full[32:SAMPLE_W-1]);
    ysat    = y_ok ? ys_full[SAMPLE_W-1:0]
                   : (ys_full[32] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_W-1){1'b1}}});
  end

  assign qf  = q_r + QUO_W'(acc[FOLD_W-1:0] == FOLD_MAX);
  assign dlt = neg_r ? (COEF_W'(0) - COEF_W'(qf)) : COEF_W'(qf);

  always_ff @(posedge clk) begin
    if (!rst_n || restore) begin
      for (int k = 0; k < FILTER_ORDER; k++) begin
        hist_r[k] <= '0;
      end
      for (int k = 0; k < NCOEF; k++) begin
        coef_r[k] <= BASE_Q55[k];
      end
    end else begin
      if (fin_go) begin
        hist_r[0] <= hval;
        for (int k = 1; k < FILTER_ORDER; k++) begin
          hist_r[k] <= hist_r[k-1];
        end
      end
      if (coef_wr) begin
        coef_r[idx_r] <= BASE_Q55[idx_r] + dlt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (fin_go) begin
      out_sample_r <= ysat;
      out_clip_r   <= !h_ok || !y_ok;
    end
  end

  assign in_ch.ready       = in_rdy;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.clipped    = out_clip_r;

  `ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_ch.valid && in_ch.ready && in_ch.req_type == REQ_SAMPLE, !in_ch.ready, "ready after sample transfer")
  `ASSERT_IMPL(a_result_from_finish, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_FIN, "result without finish step")
  `ASSERT_IMPL(a_div_nonneg, clk, rst_n, state_r == ST_TDIV, acc[ACC_W-1] == 1'b0, "negative trim remainder")

endmodule
